// File: rtl/core/fts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

    // Timing system fiducial count per rollover and its tick rate
    localparam int FIDUCIAL_PERIOD = 131040;
    localparam int TIMING_RATE_HZ  = 360;

    // Whole seconds between fiducial rollovers
    localparam int ROLL_SEC = FIDUCIAL_PERIOD / TIMING_RATE_HZ;
    localparam int REM_W    = $clog2(ROLL_SEC);

    // Reciprocal of ROLL_SEC, exact for every 32-bit dividend
    localparam int          RECIP_SHIFT = 32 + REM_W;
    localparam logic [63:0] RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'(ROLL_SEC) + 64'd1;
    localparam logic [32:0] RECIP       = RECIP_WIDE[32:0];

    localparam logic [31:0] ROLL_SEC_W = 32'(ROLL_SEC);
    localparam logic [31:0] PERIOD_W   = 32'(FIDUCIAL_PERIOD);

    localparam logic signed [30:0] NS_PER_SEC = 31'sd1000000000;

    // Configuration reset values
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd360;
    localparam logic [15:0] TOLERANCE_TICKS_RST  = 16'd396;
    localparam logic [31:0] MAX_GAP_TICKS_RST    = 32'd21600;
    localparam logic [15:0] MAX_UNSYNCED_RST     = 16'd240;

    typedef enum logic [1:0] {
        ACT_FRAME  = 2'd0,
        ACT_RESYNC = 2'd1,
        ACT_REARM  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_TICKS_PER_SECOND = 2'd0,
        CFG_TOLERANCE_TICKS  = 2'd1,
        CFG_MAX_GAP_TICKS    = 2'd2,
        CFG_MAX_UNSYNCED     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        action_t     action;
        logic [16:0] fiducial;
        logic [31:0] clock_seconds;
        logic [29:0] clock_nanoseconds;
        logic [31:0] detector_timestamp;
    } in_item_t;

    typedef struct packed {
        logic        out_of_sync;
        logic        timestep_error;
        logic        alarm;
        logic [15:0] unsynced_frames;
        logic [31:0] fiducial_gap;
    } out_item_t;

    // Item with its seconds split by the rollover period
    typedef struct packed {
        in_item_t         item;
        logic [31:0]      sec_quot;
        logic [REM_W-1:0] sec_rem;
        logic [31:0]      sec_pquot;
    } split_item_t;

endpackage

`default_nettype wire

// File: rtl/core/frame_timestamp_sync_checker.sv
// A frame transfer passes split registers s1 to s4 and then the output register.
// Throughput: one item per cycle unless a stalled output holds a frame; four register
// stages split the event seconds by the fiducial rollover period before the single
// state stage that checks the frame. Resync and rearm update state and give no result.
// Reset: asynchronous, active low; in sync, rearm pending, alarm armed, count and
// references zero, registers at their default values, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module frame_timestamp_sync_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fts_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output fts_pkg::out_item_t      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic                 split_valid;
    logic                 split_take;
    fts_pkg::split_item_t split_data;

    logic [15:0] ticks_per_second_reg;
    logic [15:0] tolerance_ticks_reg;
    logic [31:0] max_gap_ticks_reg;
    logic [15:0] max_unsynced_reg;

    logic        rearm_pending_reg;
    logic        rearm_pending_next;
    logic        in_sync_reg;
    logic        in_sync_next;
    logic        alarm_armed_reg;
    logic        alarm_armed_next;
    logic [15:0] unsynced_count_reg;
    logic [15:0] unsynced_count_next;

    logic [16:0]               ref_fiducial_reg;
    logic [31:0]               ref_seconds_reg;
    logic [29:0]               ref_nanoseconds_reg;
    logic [31:0]               ref_detector_time_reg;
    logic [31:0]               ref_quot_reg;
    logic [fts_pkg::REM_W-1:0] ref_rem_reg;
    logic [31:0]               ref_pquot_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    fts_pkg::out_item_t out_data_reg;
    fts_pkg::out_item_t out_data_next;

    logic                      out_free;
    logic                      is_frame;
    logic                      process;
    logic                      latch_refs;
    fts_pkg::out_item_t        result;

    logic [31:0]               fid_diff;
    logic [31:0]               gap_near;
    logic [31:0]               gap_roll;
    logic [31:0]               roll_adj;
    logic [31:0]               quot_diff;
    logic [31:0]               gap;
    logic                      sec_ahead;
    logic                      rem_borrow;
    logic [fts_pkg::REM_W:0]   rem_diff;
    logic [fts_pkg::REM_W-1:0] rem_delta;
    logic signed [30:0]        ns_delta;
    logic                      step_up;
    logic                      step_down;
    logic signed [32:0]        roll_count;
    logic                      roll;

    logic [31:0] dt;
    logic [47:0] scaled;
    logic [48:0] scaled_ext;
    logic [48:0] gap_ext;
    logic [48:0] tol_ext;
    logic        gap_over;
    logic        mismatch;
    logic        sync_after;
    logic [15:0] count_inc;

    fts_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .split_valid (split_valid),
        .split_take  (split_take),
        .split_data  (split_data)
    );

    // Items without a result never wait on the output register
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_frame   = split_data.item.action == fts_pkg::ACT_FRAME;
    assign split_take = !split_valid || out_free || !is_frame;
    assign process    = split_valid && split_take;

    assign cfg_ready = 1'b1;

    // Fiducial gap, no rollover: wrap a negative step by one period
    assign fid_diff = {15'd0, split_data.item.fiducial} - {15'd0, ref_fiducial_reg};
    assign gap_near = fid_diff[31] ? fid_diff + fts_pkg::PERIOD_W : fid_diff;

    // Rollover count from quotient and remainder of the seconds by the period
    assign sec_ahead  = split_data.item.clock_seconds > ref_seconds_reg;
    assign rem_borrow = split_data.sec_rem < ref_rem_reg;
    assign rem_diff   = {1'b0, split_data.sec_rem} - {1'b0, ref_rem_reg};
    assign rem_delta  = rem_borrow
        ? fts_pkg::REM_W'(rem_diff + (fts_pkg::REM_W + 1)'(fts_pkg::ROLL_SEC))
        : fts_pkg::REM_W'(rem_diff);
    assign ns_delta   = $signed({1'b0, split_data.item.clock_nanoseconds})
                      - $signed({1'b0, ref_nanoseconds_reg});

    // Nanosecond part pulls the truncated count one step down or up
    assign step_down = (rem_delta == '0 && ns_delta < 31'sd0)
                    || (rem_delta == fts_pkg::REM_W'(1) && ns_delta < -fts_pkg::NS_PER_SEC);
    assign step_up   = rem_delta == fts_pkg::REM_W'(fts_pkg::ROLL_SEC - 1)
                    && ns_delta >= fts_pkg::NS_PER_SEC;

    assign quot_diff  = split_data.sec_quot - ref_quot_reg - {31'd0, rem_borrow};
    assign roll_count = $signed({1'b0, quot_diff})
                      + (step_up ? 33'sd1 : 33'sd0) - (step_down ? 33'sd1 : 33'sd0);
    assign roll       = sec_ahead && roll_count > 33'sd0;

    assign roll_adj = (step_up ? fts_pkg::PERIOD_W : 32'd0)
                    - (step_down ? fts_pkg::PERIOD_W : 32'd0)
                    - (rem_borrow ? fts_pkg::PERIOD_W : 32'd0);
    assign gap_roll = split_data.sec_pquot - ref_pquot_reg + fid_diff + roll_adj;
    assign gap      = roll ? gap_roll : gap_near;

    // Timestamp step against the gap
    assign dt         = split_data.item.detector_timestamp - ref_detector_time_reg;
    assign scaled     = 48'(dt) * 48'(ticks_per_second_reg);
    assign scaled_ext = {1'b0, scaled};
    assign gap_ext    = {17'd0, gap};
    assign tol_ext    = {33'd0, tolerance_ticks_reg};
    assign gap_over   = (scaled_ext > gap_ext + tol_ext) || (gap_ext > scaled_ext + tol_ext);
    assign mismatch   = gap != 32'd0 && gap_over && (gap < max_gap_ticks_reg || !in_sync_reg);

    assign sync_after = in_sync_reg && !mismatch;
    assign count_inc  = (unsynced_count_reg == 16'hFFFF) ? unsynced_count_reg
                                                         : unsynced_count_reg + 16'd1;

    always_comb
    begin
        rearm_pending_next  = rearm_pending_reg;
        in_sync_next        = in_sync_reg;
        alarm_armed_next    = alarm_armed_reg;
        unsynced_count_next = unsynced_count_reg;
        latch_refs          = 1'b0;
        result              = '0;
        result.fiducial_gap = gap;
        if (process)
        begin
            unique case (split_data.item.action)
                fts_pkg::ACT_RESYNC:
                begin
                    in_sync_next        = 1'b1;
                    unsynced_count_next = 16'd0;
                    alarm_armed_next    = 1'b1;
                end
                fts_pkg::ACT_REARM:
                begin
                    rearm_pending_next = 1'b1;
                end
                fts_pkg::ACT_FRAME:
                begin
                    if (rearm_pending_reg)
                    begin
                        rearm_pending_next = 1'b0;
                        latch_refs         = 1'b1;
                    end
                    else
                    begin
                        result.timestep_error = mismatch;
                        in_sync_next          = sync_after;
                        if (!sync_after)
                        begin
                            result.out_of_sync  = 1'b1;
                            unsynced_count_next = count_inc;
                            if (count_inc > max_unsynced_reg && alarm_armed_reg)
                            begin
                                result.alarm     = 1'b1;
                                alarm_armed_next = 1'b0;
                            end
                        end
                        else
                        begin
                            unsynced_count_next = 16'd0;
                            latch_refs          = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        result.unsynced_frames = unsynced_count_next;
    end

    // Output register: load a result, drop it once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (process && is_frame)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_second_reg <= fts_pkg::TICKS_PER_SECOND_RST;
            tolerance_ticks_reg  <= fts_pkg::TOLERANCE_TICKS_RST;
            max_gap_ticks_reg    <= fts_pkg::MAX_GAP_TICKS_RST;
            max_unsynced_reg     <= fts_pkg::MAX_UNSYNCED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (fts_pkg::cfg_index_t'(cfg_index))
                fts_pkg::CFG_TICKS_PER_SECOND: ticks_per_second_reg <= cfg_data[15:0];
                fts_pkg::CFG_TOLERANCE_TICKS:  tolerance_ticks_reg  <= cfg_data[15:0];
                fts_pkg::CFG_MAX_GAP_TICKS:    max_gap_ticks_reg    <= cfg_data;
                fts_pkg::CFG_MAX_UNSYNCED:     max_unsynced_reg     <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_pending_reg     <= 1'b1;
            in_sync_reg           <= 1'b1;
            alarm_armed_reg       <= 1'b1;
            unsynced_count_reg    <= 16'd0;
            ref_fiducial_reg      <= '0;
            ref_seconds_reg       <= '0;
            ref_nanoseconds_reg   <= '0;
            ref_detector_time_reg <= '0;
            ref_quot_reg          <= '0;
            ref_rem_reg           <= '0;
            ref_pquot_reg         <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            rearm_pending_reg  <= rearm_pending_next;
            in_sync_reg        <= in_sync_next;
            alarm_armed_reg    <= alarm_armed_next;
            unsynced_count_reg <= unsynced_count_next;
            out_valid_reg      <= out_valid_next;
            if (latch_refs)
            begin
                ref_fiducial_reg      <= split_data.item.fiducial;
                ref_seconds_reg       <= split_data.item.clock_seconds;
                ref_nanoseconds_reg   <= split_data.item.clock_nanoseconds;
                ref_detector_time_reg <= split_data.item.detector_timestamp;
                ref_quot_reg          <= split_data.sec_quot;
                ref_rem_reg           <= split_data.sec_rem;
                ref_pquot_reg         <= split_data.sec_pquot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_alarm_when_unsynced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.alarm |-> out_data_reg.out_of_sync)
        else $error("alarm on a frame not marked out of sync");

    a_error_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.timestep_error |-> out_data_reg.out_of_sync)
        else $error("timestep error without loss of sync");

    a_resync_restores: assert property (@(posedge clk) disable iff (!rst_n)
        process && split_data.item.action == fts_pkg::ACT_RESYNC
        |=> in_sync_reg && alarm_armed_reg && unsynced_count_reg == 16'd0)
        else $error("resync did not restore sync state");

    a_alarm_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        process && is_frame && result.alarm |=> !alarm_armed_reg)
        else $error("alarm left armed after firing");
`endif

endmodule

`default_nettype wire

// File: rtl/core/fts_split.sv
`timescale 1ns / 1ps
`default_nettype none

module fts_split (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire fts_pkg::in_item_t   in_data,
    output logic                     split_valid,
    input  wire logic                split_take,
    output fts_pkg::split_item_t     split_data
);

    logic                s1_valid_reg;
    fts_pkg::in_item_t   s1_item_reg;
    logic                s2_valid_reg;
    fts_pkg::in_item_t   s2_item_reg;
    logic [48:0]         s2_prod_hi_reg;
    logic [48:0]         s2_prod_lo_reg;
    logic                s3_valid_reg;
    fts_pkg::in_item_t   s3_item_reg;
    logic [31:0]         s3_quot_reg;
    logic                s4_valid_reg;
    fts_pkg::split_item_t s4_item_reg;

    logic        take1;
    logic        take2;
    logic        take3;
    logic        take4;
    logic [48:0] prod_hi_next;
    logic [48:0] prod_lo_next;
    logic [64:0] prod_sum;
    logic [31:0] quot_next;
    logic [31:0] quot_times_roll;
    fts_pkg::split_item_t s4_item_next;

    // A stage loads when it is empty or its content moves on
    assign take4 = !s4_valid_reg || split_take;
    assign take3 = !s3_valid_reg || take4;
    assign take2 = !s2_valid_reg || take3;
    assign take1 = !s1_valid_reg || take2;

    assign in_stall = !take1;

    // Reciprocal product in two halves of the seconds word
    assign prod_hi_next = 49'(s1_item_reg.clock_seconds[31:16]) * 49'(fts_pkg::RECIP);
    assign prod_lo_next = 49'(s1_item_reg.clock_seconds[15:0]) * 49'(fts_pkg::RECIP);

    assign prod_sum  = {s2_prod_hi_reg, 16'd0} + {16'd0, s2_prod_lo_reg};
    assign quot_next = 32'(prod_sum >> fts_pkg::RECIP_SHIFT);

    assign quot_times_roll = s3_quot_reg * fts_pkg::ROLL_SEC_W;

    always_comb
    begin
        s4_item_next.item      = s3_item_reg;
        s4_item_next.sec_quot  = s3_quot_reg;
        s4_item_next.sec_rem   =
            fts_pkg::REM_W'(s3_item_reg.clock_seconds - quot_times_roll);
        s4_item_next.sec_pquot = s3_quot_reg * fts_pkg::PERIOD_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                s1_valid_reg <= in_valid;
            if (take2)
                s2_valid_reg <= s1_valid_reg;
            if (take3)
                s3_valid_reg <= s2_valid_reg;
            if (take4)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take1 && in_valid)
            s1_item_reg <= in_data;
        if (take2 && s1_valid_reg)
        begin
            s2_item_reg    <= s1_item_reg;
            s2_prod_hi_reg <= prod_hi_next;
            s2_prod_lo_reg <= prod_lo_next;
        end
        if (take3 && s2_valid_reg)
        begin
            s3_item_reg <= s2_item_reg;
            s3_quot_reg <= quot_next;
        end
        if (take4 && s3_valid_reg)
            s4_item_reg <= s4_item_next;
    end

    assign split_valid = s4_valid_reg;
    assign split_data  = s4_item_reg;

endmodule

`default_nettype wire
